FILE: hw/rtl/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the wallbox response frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wrp_pkg;

  // Result codes carried on the output tuser
  typedef enum logic [2:0] {
    StTaken   = 3'd0,
    StOwn     = 3'd1,
    StOther   = 3'd2,
    StCrcErr  = 3'd3,
    StHeader  = 3'd4,
    StTimeout = 3'd5,
    StShort   = 3'd6,
    StIdle    = 3'd7
  } wrp_status_e;

  // Configuration register indexes
  localparam logic [7:0]  CfgOwnAddress  = 8'd0;
  localparam logic [7:0]  CfgIdleTimeout = 8'd1;

  localparam logic [7:0]  StartFirst  = 8'h5A;
  localparam logic [7:0]  StartSecond = 8'hA5;

  // CRC16-Modbus, reflected form
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [15:0] TimeoutReset = 16'd50;

  // Last frame position whose frame still computes CRC 0 (size below five)
  localparam logic [8:0]  PosCrcZeroMax = 9'd3;
  // Positions of the address byte and the current byte; a frame ending before the current byte is short
  localparam logic [8:0]  PosAddress = 9'd4;
  localparam logic [8:0]  PosCurrent = 9'd7;

endpackage

`default_nettype wire

FILE: hw/rtl/wrp_crc16_byte.sv
// ----------------------------------------------------------------------------
// wrp_crc16_byte
// One-byte update of a CRC16-Modbus accumulator, eight bit steps unrolled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wrp_crc16_byte (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ wrp_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wallbox_response_frame_parser.sv
// Each accepted input item's result is registered and shows on the master side in the next cycle.
// Throughput: one item per cycle while the master side is ready; every item gives exactly one result item.
// The whole byte step (header check, CRC16 byte update, frame end check) sits
// between the input handshake and the result register.
// Reset (rst_ni low, asynchronous): parse cleared, CRC at 0xFFFF, no stored
// current, own_address 0, idle timeout 50 tick items, output empty.
`timescale 1ns / 1ps
`default_nettype none

module wallbox_response_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic        s_axis_tuser,  // [0] req_type
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // [7:0] frame_address, [15:8] current_amps,
                                          // [16] current_changed, [23:17] zero
  output logic      [2:0]  m_axis_tuser,  // [2:0] status
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  // configuration
  logic [7:0]  own_addr_q;
  logic [15:0] timeout_q;

  // parse state
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  cur_q, cur_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  stored_q, stored_d;
  logic        stored_vld_q, stored_vld_d;

  // result register
  logic        out_vld_q;
  logic [7:0]  out_addr_q, out_addr_d;
  logic [7:0]  out_cur_q, out_cur_d;
  logic        out_chg_q, out_chg_d;
  wrp_pkg::wrp_status_e out_st_q, out_st_d;

  logic        in_fire;
  logic        is_tick;
  logic [7:0]  rx;
  logic [15:0] crc_upd;
  logic [15:0] crc_step;
  logic [7:0]  len_eff;
  logic [16:0] idle_inc;
  logic [15:0] crc_calc;
  logic [15:0] crc_remote;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_tick       = s_axis_tuser;
  assign rx            = s_axis_tdata;

  wrp_crc16_byte u_crc (
    .crc_i  (crc_q),
    .data_i (rx),
    .crc_o  (crc_upd)
  );

  assign len_eff    = (pos_q == 9'd2) ? rx : len_q;
  assign crc_step   = (pos_q > 9'd2 && pos_q <= {1'b0, len_q}) ? crc_upd : crc_q;
  assign idle_inc   = {1'b0, idle_q} + 17'd1;
  assign crc_calc   = (pos_q <= wrp_pkg::PosCrcZeroMax) ? 16'h0000 : crc_step;
  assign crc_remote = {rx, prev_q};

  always_comb begin
    pos_d        = pos_q;
    len_d        = len_q;
    crc_d        = crc_q;
    prev_d       = prev_q;
    addr_d       = addr_q;
    cur_d        = cur_q;
    idle_d       = idle_q;
    stored_d     = stored_q;
    stored_vld_d = stored_vld_q;
    out_st_d     = wrp_pkg::StIdle;
    out_addr_d   = 8'h00;
    out_cur_d    = 8'h00;
    out_chg_d    = 1'b0;

    if (is_tick) begin
      if (idle_inc > {1'b0, timeout_q}) begin
        out_st_d = (pos_q != 9'd0) ? wrp_pkg::StTimeout : wrp_pkg::StIdle;
        pos_d    = 9'd0;
        len_d    = 8'h00;
        crc_d    = wrp_pkg::CrcInit;
        idle_d   = 16'h0000;
      end else begin
        idle_d   = idle_inc[15:0];
        out_st_d = wrp_pkg::StIdle;
      end
    end else begin
      prev_d = rx;
      if (pos_q == wrp_pkg::PosAddress) addr_d = rx;
      if (pos_q == wrp_pkg::PosCurrent) cur_d = rx;

      if (pos_q == 9'd0 || pos_q == 9'd1) begin
        if (rx == ((pos_q == 9'd0) ? wrp_pkg::StartFirst : wrp_pkg::StartSecond)) begin
          pos_d    = pos_q + 9'd1;
          idle_d   = 16'h0000;
          out_st_d = wrp_pkg::StTaken;
        end else begin
          pos_d    = 9'd0;
          len_d    = 8'h00;
          crc_d    = wrp_pkg::CrcInit;
          out_st_d = wrp_pkg::StHeader;
        end
      end else begin
        if (pos_q == 9'd2) len_d = rx;
        crc_d = crc_step;
        if (pos_q < ({1'b0, len_eff} + 9'd2)) begin
          pos_d    = pos_q + 9'd1;
          idle_d   = 16'h0000;
          out_st_d = wrp_pkg::StTaken;
        end else begin
          // frame end: always clears the parse
          pos_d = 9'd0;
          len_d = 8'h00;
          crc_d = wrp_pkg::CrcInit;
          if (crc_calc != crc_remote) begin
            out_st_d = wrp_pkg::StCrcErr;
          end else if (pos_q < wrp_pkg::PosCurrent) begin
            out_st_d = wrp_pkg::StShort;
          end else begin
            out_addr_d = addr_d;
            out_cur_d  = cur_d;
            if (addr_d == own_addr_q) begin
              out_st_d = wrp_pkg::StOwn;
              if (!stored_vld_q || stored_q != cur_d) begin
                out_chg_d    = 1'b1;
                stored_d     = cur_d;
                stored_vld_d = 1'b1;
              end
            end else begin
              out_st_d = wrp_pkg::StOther;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= 8'h00;
      timeout_q    <= wrp_pkg::TimeoutReset;
      pos_q        <= 9'd0;
      len_q        <= 8'h00;
      crc_q        <= wrp_pkg::CrcInit;
      prev_q       <= 8'h00;
      addr_q       <= 8'h00;
      cur_q        <= 8'h00;
      idle_q       <= 16'h0000;
      stored_q     <= 8'h00;
      stored_vld_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == wrp_pkg::CfgOwnAddress) own_addr_q <= cfg_data_i[7:0];
        if (cfg_index_i == wrp_pkg::CfgIdleTimeout) timeout_q <= cfg_data_i;
      end
      if (in_fire) begin
        pos_q        <= pos_d;
        len_q        <= len_d;
        crc_q        <= crc_d;
        prev_q       <= prev_d;
        addr_q       <= addr_d;
        cur_q        <= cur_d;
        idle_q       <= idle_d;
        stored_q     <= stored_d;
        stored_vld_q <= stored_vld_d;
        out_vld_q    <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_st_q   <= out_st_d;
      out_addr_q <= out_addr_d;
      out_cur_q  <= out_cur_d;
      out_chg_q  <= out_chg_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {7'b0000000, out_chg_q, out_cur_q, out_addr_q};

endmodule

`default_nettype wire

FILE: hw/rtl/wrp_checker.sv
// ----------------------------------------------------------------------------
// wrp_checker
// Port-level checks for the wallbox response frame parser, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wrp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // every accepted item shows a result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  // address and current only on completed good frames
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != wrp_pkg::StOwn && m_axis_tuser != wrp_pkg::StOther
      |-> m_axis_tdata[16:0] == 17'd0)
    else $error("payload set on non-frame result");

  // change flag only on own frames
  a_changed_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tuser == wrp_pkg::StOwn)
    else $error("change flag without own frame");

endmodule

bind wallbox_response_frame_parser wrp_checker u_wrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
